>>> design/dimh_pkg.sv
// Shared types, constants and helpers for the dual indexed max-heap.
`timescale 1ns / 1ps
`default_nettype none

package dimh_pkg;

  localparam int EdgeW       = 10;
  localparam int ScoreW      = 32;
  localparam int MaxEdgesDef = 1024;

  localparam logic [1:0] CmdLoad      = 2'd0;
  localparam logic [1:0] CmdAddForbid = 2'd1;
  localparam logic [1:0] CmdAddPerm   = 2'd2;
  localparam logic [1:0] CmdRemove    = 2'd3;

  localparam logic signed [ScoreW-1:0] ScoreMin = {1'b1, {(ScoreW-1){1'b0}}};
  localparam logic signed [ScoreW-1:0] ScoreMax = {1'b0, {(ScoreW-1){1'b1}}};

  typedef enum logic [1:0] {
    OP_NOP,
    OP_LOAD,
    OP_ADD,
    OP_REMOVE
  } heap_op_e;

  typedef struct packed {
    logic [EdgeW-1:0]         edge_id;
    logic signed [ScoreW-1:0] score;
  } slot_entry_t;

  typedef struct packed {
    heap_op_e                 op;
    logic [EdgeW-1:0]         edge_id;
    logic signed [ScoreW-1:0] value;
  } heap_req_t;

  typedef struct packed {
    logic                     idle;
    logic [EdgeW-1:0]         root_edge;
    logic                     root_nonneg;
    logic signed [ScoreW-1:0] edge_score;
  } heap_rsp_t;

  function automatic logic signed [ScoreW-1:0] sat_add(
    input logic signed [ScoreW-1:0] a,
    input logic signed [ScoreW-1:0] b
  );
    logic signed [ScoreW:0] s;
    s = {a[ScoreW-1], a} + {b[ScoreW-1], b};
    if (s[ScoreW] != s[ScoreW-1]) begin
      sat_add = s[ScoreW] ? ScoreMin : ScoreMax;
    end else begin
      sat_add = s[ScoreW-1:0];
    end
  endfunction

endpackage

`default_nettype wire

>>> design/dimh_heap.sv
// One indexed binary max-heap: slot and position memories with a sift sequencer.
`timescale 1ns / 1ps
`default_nettype none

module dimh_heap #(
  parameter int unsigned MaxEdges = dimh_pkg::MaxEdgesDef
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start_i,
  input  dimh_pkg::heap_req_t                   req_i,
  input  logic [$clog2(MaxEdges+1)-1:0]         count_i,
  output dimh_pkg::heap_rsp_t                   rsp_o
);
  import dimh_pkg::*;

  localparam int SlotW  = $clog2(MaxEdges + 1);
  localparam int IdxW   = $clog2(MaxEdges);
  localparam int ChildW = SlotW + 1;

  localparam int StW = 4;
  localparam logic [StW-1:0] S_IDLE   = 4'd0;
  localparam logic [StW-1:0] S_PRD    = 4'd1;
  localparam logic [StW-1:0] S_CHK    = 4'd2;
  localparam logic [StW-1:0] S_UP_RD  = 4'd3;
  localparam logic [StW-1:0] S_UP_CMP = 4'd4;
  localparam logic [StW-1:0] S_DN_RDL = 4'd5;
  localparam logic [StW-1:0] S_DN_RDR = 4'd6;
  localparam logic [StW-1:0] S_DN_CMP = 4'd7;
  localparam logic [StW-1:0] S_FIN    = 4'd8;
  localparam logic [StW-1:0] S_RP     = 4'd9;
  localparam logic [StW-1:0] S_RS     = 4'd10;
  localparam logic [StW-1:0] S_RR     = 4'd11;
  localparam logic [StW-1:0] S_RT     = 4'd12;

  logic [StW-1:0]           state_q, state_d;
  heap_op_e                 op_q, op_d;
  logic [EdgeW-1:0]         eid_q, eid_d;
  logic signed [ScoreW-1:0] val_q, val_d;
  logic [SlotW-1:0]         cnt_q, cnt_d;
  logic [SlotW-1:0]         p_q, p_d;
  slot_entry_t              cur_q, cur_d;
  slot_entry_t              lch_q, lch_d;
  logic signed [ScoreW-1:0] escore_q, escore_d;
  logic [EdgeW-1:0]         root_edge_q, root_edge_d;
  logic                     root_nn_q, root_nn_d;

  slot_entry_t      slot_mem [MaxEdges+1];
  logic [SlotW-1:0] pos_mem  [MaxEdges];
  slot_entry_t      slot_rd_q;
  logic [SlotW-1:0] pos_rd_q;

  logic             slot_re, slot_we, pos_re, pos_we;
  logic [SlotW-1:0] slot_ra, slot_wa, pos_wd;
  slot_entry_t      slot_wd;
  logic [IdxW-1:0]  pos_ra, pos_wa;

  logic [ChildW-1:0] l_idx, r_idx, cnt_x;
  logic              r_in, hl, hr;

  assign l_idx = {p_q, 1'b0};
  assign r_idx = {p_q, 1'b1};
  assign cnt_x = ChildW'(cnt_q);
  assign r_in  = r_idx <= cnt_x;
  assign hl    = $signed(cur_q.score) < $signed(lch_q.score);
  assign hr    = r_in && ($signed(cur_q.score) < $signed(slot_rd_q.score));

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    eid_d       = eid_q;
    val_d       = val_q;
    cnt_d       = cnt_q;
    p_d         = p_q;
    cur_d       = cur_q;
    lch_d       = lch_q;
    escore_d    = escore_q;
    root_edge_d = root_edge_q;
    root_nn_d   = root_nn_q;
    slot_re     = 1'b0;
    slot_ra     = '0;
    slot_we     = 1'b0;
    slot_wa     = '0;
    slot_wd     = '0;
    pos_re      = 1'b0;
    pos_ra      = '0;
    pos_we      = 1'b0;
    pos_wa      = '0;
    pos_wd      = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          op_d  = req_i.op;
          eid_d = req_i.edge_id;
          val_d = req_i.value;
          cnt_d = count_i;
          unique case (req_i.op)
            OP_LOAD: begin
              cur_d   = '{edge_id: req_i.edge_id, score: req_i.value};
              p_d     = count_i;
              state_d = (count_i > SlotW'(1)) ? S_UP_RD : S_FIN;
            end
            OP_ADD, OP_REMOVE: begin
              pos_re  = 1'b1;
              pos_ra  = IdxW'(req_i.edge_id);
              state_d = S_PRD;
            end
            default: state_d = S_RP;
          endcase
        end
      end
      S_PRD: begin
        p_d     = pos_rd_q;
        slot_re = 1'b1;
        slot_ra = pos_rd_q;
        state_d = S_CHK;
      end
      S_CHK: begin
        if (op_q == OP_REMOVE) begin
          cur_d   = '{edge_id: eid_q, score: ScoreMin};
          state_d = S_DN_RDL;
        end else if (val_q == '0 || $signed(slot_rd_q.score) < 0) begin
          state_d = S_RP;
        end else begin
          cur_d = '{edge_id: eid_q, score: sat_add(slot_rd_q.score, val_q)};
          if (val_q > 0) begin
            state_d = (p_q > SlotW'(1)) ? S_UP_RD : S_FIN;
          end else begin
            state_d = S_DN_RDL;
          end
        end
      end
      S_UP_RD: begin
        slot_re = 1'b1;
        slot_ra = p_q >> 1;
        state_d = S_UP_CMP;
      end
      S_UP_CMP: begin
        if ($signed(slot_rd_q.score) < $signed(cur_q.score)) begin
          // move the parent down into the hole
          slot_we = 1'b1;
          slot_wa = p_q;
          slot_wd = slot_rd_q;
          pos_we  = 1'b1;
          pos_wa  = IdxW'(slot_rd_q.edge_id);
          pos_wd  = p_q;
          p_d     = p_q >> 1;
          state_d = ((p_q >> 1) > SlotW'(1)) ? S_UP_RD : S_FIN;
        end else begin
          state_d = S_FIN;
        end
      end
      S_DN_RDL: begin
        if (l_idx > cnt_x) begin
          state_d = S_FIN;
        end else begin
          slot_re = 1'b1;
          slot_ra = SlotW'(l_idx);
          state_d = S_DN_RDR;
        end
      end
      S_DN_RDR: begin
        lch_d = slot_rd_q;
        if (r_in) begin
          slot_re = 1'b1;
          slot_ra = SlotW'(r_idx);
        end
        state_d = S_DN_CMP;
      end
      S_DN_CMP: begin
        if (!hl && !hr) begin
          state_d = S_FIN;
        end else begin
          // right child wins only when strictly larger than the left
          slot_we = 1'b1;
          slot_wa = p_q;
          pos_we  = 1'b1;
          pos_wd  = p_q;
          if (r_in && ($signed(lch_q.score) < $signed(slot_rd_q.score))) begin
            slot_wd = slot_rd_q;
            pos_wa  = IdxW'(slot_rd_q.edge_id);
            p_d     = SlotW'(r_idx);
          end else begin
            slot_wd = lch_q;
            pos_wa  = IdxW'(lch_q.edge_id);
            p_d     = SlotW'(l_idx);
          end
          state_d = S_DN_RDL;
        end
      end
      S_FIN: begin
        slot_we = 1'b1;
        slot_wa = p_q;
        slot_wd = cur_q;
        pos_we  = 1'b1;
        pos_wa  = IdxW'(cur_q.edge_id);
        pos_wd  = p_q;
        state_d = S_RP;
      end
      S_RP: begin
        pos_re  = 1'b1;
        pos_ra  = IdxW'(eid_q);
        state_d = S_RS;
      end
      S_RS: begin
        slot_re = 1'b1;
        slot_ra = pos_rd_q;
        state_d = S_RR;
      end
      S_RR: begin
        escore_d = slot_rd_q.score;
        slot_re  = 1'b1;
        slot_ra  = SlotW'(1);
        state_d  = S_RT;
      end
      S_RT: begin
        root_edge_d = slot_rd_q.edge_id;
        root_nn_d   = ~slot_rd_q.score[ScoreW-1];
        state_d     = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      op_q    <= OP_NOP;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
    end
  end

  always_ff @(posedge clk_i) begin
    eid_q       <= eid_d;
    val_q       <= val_d;
    cnt_q       <= cnt_d;
    p_q         <= p_d;
    cur_q       <= cur_d;
    lch_q       <= lch_d;
    escore_q    <= escore_d;
    root_edge_q <= root_edge_d;
    root_nn_q   <= root_nn_d;
  end

  always_ff @(posedge clk_i) begin
    if (slot_we) begin
      slot_mem[slot_wa] <= slot_wd;
    end
    if (slot_re) begin
      slot_rd_q <= slot_mem[slot_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pos_we) begin
      pos_mem[pos_wa] <= pos_wd;
    end
    if (pos_re) begin
      pos_rd_q <= pos_mem[pos_ra];
    end
  end

  assign rsp_o = '{idle: (state_q == S_IDLE), root_edge: root_edge_q,
                   root_nonneg: root_nn_q, edge_score: escore_q};

`ifndef SYNTHESIS
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> state_q == S_IDLE)
    else $error("heap started while busy");
  a_hole_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_UP_RD || state_q == S_UP_CMP || state_q == S_DN_RDL ||
     state_q == S_DN_CMP || state_q == S_FIN) |-> p_q != '0)
    else $error("sift hole at slot zero");
  a_up_moves_parent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_UP_CMP && slot_we) |=> p_q == ($past(p_q) >> 1))
    else $error("upward swap did not move to parent");
  a_down_moves_child: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DN_CMP && slot_we) |=> p_q > $past(p_q))
    else $error("downward swap did not move to child");
`endif

endmodule

`default_nettype wire

>>> design/dual_indexed_max_heap_top.sv
// Top level of the dual indexed max-heap: command decode, edge count and result register.
`timescale 1ns / 1ps
`default_nettype none

// Sequence, accept to result: a rejected command only reads back the edge score and the root;
//   a load sifts up comparing with each parent, a raise reads the position and slot and then
//   sifts up, a lower or remove sifts down comparing each child pair (up to
//   log2(MaxEdges) levels); the slower heap decides.
// Throughput: one item in flight; the next is taken the cycle after the result is
//   registered, and the result is not registered while the output is stalled. Reset clears the edge
//   count and all control; the memories are not cleared.

module dual_indexed_max_heap_top #(
  parameter int unsigned MaxEdges = dimh_pkg::MaxEdgesDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [1:0]                          command_i,
  input  logic [dimh_pkg::EdgeW-1:0]          edge_id_i,
  input  logic signed [dimh_pkg::ScoreW-1:0]  forbid_cost_i,
  input  logic signed [dimh_pkg::ScoreW-1:0]  permanent_cost_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [dimh_pkg::EdgeW-1:0]          top_forbid_edge_o,
  output logic                                top_forbid_valid_o,
  output logic [dimh_pkg::EdgeW-1:0]          top_permanent_edge_o,
  output logic                                top_permanent_valid_o,
  output logic signed [dimh_pkg::ScoreW-1:0]  edge_forbid_score_o,
  output logic signed [dimh_pkg::ScoreW-1:0]  edge_permanent_score_o,
  output logic                                error_o
);
  import dimh_pkg::*;

  localparam int CntW = $clog2(MaxEdges + 1);
  localparam int CmpW = (CntW > EdgeW) ? CntW : EdgeW;
  localparam logic [CntW-1:0] MaxCnt = CntW'(MaxEdges);

  localparam logic [1:0] T_IDLE = 2'd0;
  localparam logic [1:0] T_RUN  = 2'd1;
  localparam logic [1:0] T_HOLD = 2'd2;

  logic [1:0]      tstate_q, tstate_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            err_q, pres_q;
  logic            out_valid_q;

  logic [EdgeW-1:0]         tf_edge_q, tp_edge_q;
  logic                     tf_valid_q, tp_valid_q, oerr_q;
  logic signed [ScoreW-1:0] ef_score_q, ep_score_q;

  logic            accept, load_ok, present, err, both_idle, emit;
  logic [CmpW-1:0] cnt_x, eid_x;
  heap_req_t       freq, preq;
  heap_rsp_t       frsp, prsp;

  assign in_ready_o = (tstate_q == T_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  // Decode the command against the current edge count.
  assign cnt_x   = CmpW'(cnt_q);
  assign eid_x   = CmpW'(edge_id_i);
  assign load_ok = (eid_x == cnt_x) && (cnt_q != MaxCnt);
  assign present = eid_x < cnt_x;
  assign err     = (command_i == CmdLoad) ? !load_ok : !present;
  assign cnt_d   = (accept && command_i == CmdLoad && load_ok) ? cnt_q + CntW'(1) : cnt_q;

  always_comb begin
    freq = '{op: OP_NOP, edge_id: edge_id_i, value: forbid_cost_i};
    preq = '{op: OP_NOP, edge_id: edge_id_i, value: permanent_cost_i};
    if (!err) begin
      unique case (command_i)
        CmdLoad: begin
          freq.op = OP_LOAD;
          preq.op = OP_LOAD;
        end
        CmdAddForbid: freq.op = OP_ADD;
        CmdAddPerm:   preq.op = OP_ADD;
        CmdRemove: begin
          freq.op = OP_REMOVE;
          preq.op = OP_REMOVE;
        end
        default: freq.op = OP_NOP;
      endcase
    end
  end

  dimh_heap #(.MaxEdges(MaxEdges)) u_forbid (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept),
    .req_i   (freq),
    .count_i (cnt_d),
    .rsp_o   (frsp)
  );

  dimh_heap #(.MaxEdges(MaxEdges)) u_permanent (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept),
    .req_i   (preq),
    .count_i (cnt_d),
    .rsp_o   (prsp)
  );

  // Both heaps finish in their own time; hold the result until the output is free.
  assign both_idle = frsp.idle && prsp.idle;
  assign emit = (tstate_q == T_RUN || tstate_q == T_HOLD) && both_idle &&
                (!out_valid_q || out_ready_i);

  always_comb begin
    tstate_d = tstate_q;
    unique case (tstate_q)
      T_IDLE: if (accept) tstate_d = T_RUN;
      T_RUN, T_HOLD: begin
        if (emit) begin
          tstate_d = T_IDLE;
        end else if (both_idle) begin
          tstate_d = T_HOLD;
        end
      end
      default: tstate_d = T_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tstate_q    <= T_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      tstate_q <= tstate_d;
      cnt_q    <= cnt_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      err_q  <= err;
      pres_q <= eid_x < CmpW'(cnt_d);
    end
    if (emit) begin
      // An empty heap reports edge 0 and no valid top; an unloaded edge reports zero scores.
      tf_edge_q  <= (cnt_q != '0) ? frsp.root_edge : '0;
      tf_valid_q <= (cnt_q != '0) && frsp.root_nonneg;
      tp_edge_q  <= (cnt_q != '0) ? prsp.root_edge : '0;
      tp_valid_q <= (cnt_q != '0) && prsp.root_nonneg;
      ef_score_q <= pres_q ? frsp.edge_score : '0;
      ep_score_q <= pres_q ? prsp.edge_score : '0;
      oerr_q     <= err_q;
    end
  end

  assign out_valid_o            = out_valid_q;
  assign top_forbid_edge_o      = tf_edge_q;
  assign top_forbid_valid_o     = tf_valid_q;
  assign top_permanent_edge_o   = tp_edge_q;
  assign top_permanent_valid_o  = tp_valid_q;
  assign edge_forbid_score_o    = ef_score_q;
  assign edge_permanent_score_o = ep_score_q;
  assign error_o                = oerr_q;

`ifndef SYNTHESIS
  a_ready_heaps_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> both_idle)
    else $error("input ready while a heap is busy");
  a_out_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> out_valid_o &&
      $stable({tf_edge_q, tf_valid_q, tp_edge_q, tp_valid_q, ef_score_q, ep_score_q, oerr_q}))
    else $error("result item changed while waiting");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= MaxCnt)
    else $error("edge count above capacity");
`endif

endmodule

`default_nettype wire
